// ----- rtl/assert_macros.svh -----
// Assertion helpers for the keypad scanner RTL.
// Checks are compiled in for simulation and left out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is asserted (active low).
`define KPD_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("keypad scanner check failed");

// Clocked check that also holds during reset.
`define KPD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("keypad scanner check failed");

`else

`define KPD_ASSERT(lbl, clk, rst_n, prop)
`define KPD_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// ----- rtl/kpd_pkg.sv -----
// ----------------------------------------------------------------------------
// kpd_pkg
// Shared types and constants for the two-column keypad matrix scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package kpd_pkg;

  localparam int NUM_BUTTONS = 17;
  localparam int ROW_W       = 8;
  localparam int IDX_W       = 5;
  localparam int PHASE_W     = 2;

  // Scan phase codes; the unused code three acts as column-0 select
  localparam logic [PHASE_W-1:0] PH_COL0 = 2'd0;
  localparam logic [PHASE_W-1:0] PH_COL1 = 2'd1;
  localparam logic [PHASE_W-1:0] PH_CAPT = 2'd2;

  // Column select codes
  localparam logic COL_FIRST  = 1'b0;
  localparam logic COL_SECOND = 1'b1;

  // Input word: one poll tick
  typedef struct packed {
    logic [ROW_W-1:0] row_levels;
    logic             power_pin;
  } kpd_in_t;

  // Output word: one result
  typedef struct packed {
    logic                   column_select;
    logic [NUM_BUTTONS-1:0] button_state;
    logic                   event_valid;
    logic [IDX_W-1:0]       button_index;
    logic                   last;
  } kpd_out_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic accept;  // take the input word
    logic step;    // advance the change walk by one button
  } kpd_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic has_events;  // accepted tick produces change events
    logic hit;         // current walk position holds a change
    logic rest_zero;   // no change left above the current position
  } kpd_sts_t;

endpackage

`default_nettype wire

// ----- rtl/keypad_matrix_scan_change_events.sv -----
// ----------------------------------------------------------------------------
// keypad_matrix_scan_change_events
// Two-column keypad scanner: three-phase poll tick, 17-bit pressed state,
// one result word per changed button in the event span.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per poll tick (sampled row pins, power pin), taken when
//           in_valid is high and in_stall is low.
//   out_* : result words, taken when out_valid is high and out_stall is low;
//           each tick gives one or more words, the final one has last set.
//   Phase 0 and phase 1 ticks, and a capture tick with no change, give one
//   word in the cycle after acceptance. A capture tick with changes walks the
//   pending-change mask one button per cycle while the output is not stalled,
//   from FIRST_EVENT_BIT up to the highest changed button.
//   A new tick is taken once the walk is over and the output register is
//   empty, so no tick is taken while words of the previous one are pending.
//   A stalled output word holds and the walk pauses until it is taken.
//   Reset clears the scan phase (column 0 next), captured rows and stored
//   state; no word is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module keypad_matrix_scan_change_events import kpd_pkg::*; #(
  parameter int FIRST_EVENT_BIT = 0,
  parameter int END_EVENT_BIT   = 17
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire kpd_in_t in_data,
  output logic         out_valid,
  input  wire logic    out_stall,
  output kpd_out_t     out_data
);

  kpd_cmd_t cmd;
  kpd_sts_t sts;

  kpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  kpd_dp #(
    .FIRST_EVENT_BIT (FIRST_EVENT_BIT),
    .END_EVENT_BIT   (END_EVENT_BIT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_data),
    .sts      (sts),
    .out_word (out_data)
  );

  // Checks
  `KPD_ASSERT(a_accept_out_empty, clk, rst_n, (in_valid && !in_stall) |-> !out_valid)
  `KPD_ASSERT(a_event_col_second, clk, rst_n, (out_valid && out_data.event_valid) |-> out_data.column_select)
  `KPD_ASSERT(a_plain_is_last, clk, rst_n, (out_valid && !out_data.event_valid) |-> out_data.last)
  `KPD_ASSERT(a_cmd_exclusive, clk, rst_n, !(cmd.accept && cmd.step))

endmodule

`default_nettype wire

// ----- rtl/kpd_dp.sv -----
// ----------------------------------------------------------------------------
// kpd_dp
// Scanner datapath: scan phase, captured rows, stored button state, the
// pending-change mask with its walk counter, and the output word register.
// ----------------------------------------------------------------------------
`default_nettype none

module kpd_dp import kpd_pkg::*; #(
  parameter int FIRST_EVENT_BIT = 0,
  parameter int END_EVENT_BIT   = 17
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire kpd_cmd_t cmd,
  input  wire kpd_in_t  in_word,
  output kpd_sts_t      sts,
  output kpd_out_t      out_word
);

  logic [PHASE_W-1:0]     phase_r,      phase_nxt;
  logic [ROW_W-1:0]       first_rows_r, first_rows_nxt;
  logic [NUM_BUTTONS-1:0] stored_r,     stored_nxt;
  logic [NUM_BUTTONS-1:0] pend_r,       pend_nxt;
  logic [IDX_W-1:0]       bit_r,        bit_nxt;
  kpd_out_t               out_r,        out_nxt;

  logic [ROW_W-1:0]       rows_pressed;
  logic [NUM_BUTTONS-1:0] fresh;
  logic [NUM_BUTTONS-1:0] span;
  logic [NUM_BUTTONS-1:0] changes;
  logic [NUM_BUTTONS-1:0] above;
  logic                   col_next;

  // Event span mask and positions above the walk counter
  always_comb begin
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      span[i]  = (i >= FIRST_EVENT_BIT) && (i < END_EVENT_BIT);
      above[i] = (IDX_W'(i) > bit_r);
    end
  end

  // New pressed state; rows are active low
  assign rows_pressed = ~in_word.row_levels;
  assign fresh        = {in_word.power_pin, rows_pressed, first_rows_r};
  assign changes      = (stored_r ^ fresh) & span;

  assign sts.has_events = (phase_r == PH_CAPT) && (|changes);
  assign sts.hit        = pend_r[bit_r];
  assign sts.rest_zero  = ~|(pend_r & above);

  // Phase sequencing on an accepted tick, and the change walk on a step
  always_comb begin
    phase_nxt      = phase_r;
    first_rows_nxt = first_rows_r;
    stored_nxt     = stored_r;
    pend_nxt       = pend_r;
    bit_nxt        = bit_r;
    col_next       = COL_SECOND;
    out_nxt        = out_r;
    if (cmd.accept) begin
      unique case (phase_r)
        PH_COL1: begin
          first_rows_nxt = rows_pressed;
          phase_nxt      = PH_CAPT;
          col_next       = COL_SECOND;
        end
        PH_CAPT: begin
          stored_nxt = fresh;
          pend_nxt   = changes;
          bit_nxt    = IDX_W'(FIRST_EVENT_BIT);
          phase_nxt  = PH_COL0;
          col_next   = COL_SECOND;
        end
        default: begin
          first_rows_nxt = '0;
          phase_nxt      = PH_COL1;
          col_next       = COL_FIRST;
        end
      endcase
      // Single non-event result; unused when the tick has events
      out_nxt.column_select = col_next;
      out_nxt.button_state  = stored_nxt;
      out_nxt.event_valid   = 1'b0;
      out_nxt.button_index  = '0;
      out_nxt.last          = 1'b1;
    end else if (cmd.step) begin
      // Walk one button; a hit loads an event word and clears its bit
      bit_nxt = bit_r + IDX_W'(1);
      if (pend_r[bit_r]) begin
        pend_nxt[bit_r]       = 1'b0;
        out_nxt.column_select = COL_SECOND;
        out_nxt.button_state  = stored_r;
        out_nxt.event_valid   = 1'b1;
        out_nxt.button_index  = bit_r;
        out_nxt.last          = sts.rest_zero;
      end
    end
  end

  // Scan state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_COL0;
      first_rows_r <= '0;
      stored_r     <= '0;
      pend_r       <= '0;
    end else begin
      phase_r      <= phase_nxt;
      first_rows_r <= first_rows_nxt;
      stored_r     <= stored_nxt;
      pend_r       <= pend_nxt;
    end
  end

  // Walk counter and output word
  always_ff @(posedge clk) begin
    bit_r <= bit_nxt;
    out_r <= out_nxt;
  end

  assign out_word = out_r;

endmodule

`default_nettype wire

// ----- rtl/kpd_ctrl.sv -----
// ----------------------------------------------------------------------------
// kpd_ctrl
// Scanner controller: input handshake, change-walk sequencing and the
// output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module kpd_ctrl import kpd_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire logic     out_stall,
  input  wire kpd_sts_t sts,
  output kpd_cmd_t      cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || !out_stall;

  // Take a tick only when idle with the output register empty
  assign in_stall   = (state_r != ST_IDLE) || out_valid_r;
  assign cmd.accept = in_valid && !in_stall;
  assign cmd.step   = (state_r == ST_WALK) && out_free;

  // Next state and output valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.accept) begin
          if (sts.has_events) begin
            state_nxt = ST_WALK;
          end else begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      ST_WALK: begin
        if (cmd.step && sts.hit) begin
          out_valid_nxt = 1'b1;
          if (sts.rest_zero) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
